// ===== rtl/rdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types and constants for the radial distortion sampler
// Field widths, payload structs and register indexes used by the sampler.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  localparam int IN_BITS      = 11;
  localparam int COORD_BITS   = 11;
  localparam int FRAC_BITS    = 8;
  localparam int ALPHA_BITS   = 16;
  localparam int HALF_BITS    = IN_BITS - 1;
  localparam int DELTA_BITS   = IN_BITS + 1;
  localparam int R2_BITS      = 2 * IN_BITS + 1;
  localparam int PROD_BITS    = ALPHA_BITS + R2_BITS;
  localparam int DIV_BITS     = 2 * HALF_BITS;
  localparam int SCALE_SHIFT  = 16;
  localparam int Q_BITS       = 44;
  localparam int LOW_BITS     = Q_BITS - SCALE_SHIFT;
  localparam int TOP_BITS     = PROD_BITS - LOW_BITS;
  localparam int M_BITS       = Q_BITS + 2;
  localparam int M_FRAC       = 30;
  localparam int OFF_SHIFT    = M_FRAC - FRAC_BITS;
  localparam int PROD2_BITS   = DELTA_BITS + M_BITS;
  localparam int OFF_BITS     = PROD2_BITS - OFF_SHIFT;
  localparam int REF_BITS     = OFF_BITS + 1;
  localparam int LIM_BITS     = IN_BITS + 2 + FRAC_BITS;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [IN_BITS-1:0]    PATCH_WIDTH_RST    = 11'd960;
  localparam logic [IN_BITS-1:0]    PATCH_HEIGHT_RST   = 11'd1080;
  localparam logic [IN_BITS-1:0]    RESIZED_HEIGHT_RST = 11'd540;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RST          = 16'd1638;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATCH_WIDTH,
    CFG_PATCH_HEIGHT,
    CFG_RESIZED_HEIGHT,
    CFG_ALPHA
  } cfg_idx_t;

  typedef struct packed {
    logic [IN_BITS-1:0] out_x;
    logic [IN_BITS-1:0] out_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic [FRAC_BITS-1:0]  col_fraction;
    logic [FRAC_BITS-1:0]  row_fraction;
    logic                  in_range;
  } out_item_t;

  typedef struct packed {
    logic [IN_BITS-1:0]           x;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
  } coord_t;

endpackage

// ===== rtl/radial_distortion_sample_coord_top.sv =====
// ----------------------------------------------------------------------------
// radial_distortion_sample_coord_top: radial warp source sampling point
// Maps an output pixel position to the source point of a radial lens warp,
// as integer column and row plus bilinear fractions and an in-range flag.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the in_ channel (valid/stall) as an output pixel position and
// leave on the out_ channel as the source sampling point. One item may be
// transferred on every clock while in_stall is low, and a new item may enter
// before earlier ones leave. The pipeline holds the 44-stage restoring divider
// that forms alpha * r^2 / hx^2, one quotient bit per stage, plus stages of
// squaring, multiplying, scaling and range check.
// The cfg_ port writes one register per cycle with cfg_wr_en, cfg_index and
// cfg_wdata; write only while no transfer is in flight.
// A synchronous reset (rst_n low) empties the pipeline and restores the
// register defaults. When the receiver stalls, the output register holds its
// result and the next one lands in a single skid entry; only once that entry
// is full does in_stall rise and the whole pipeline freeze without loss.
// ----------------------------------------------------------------------------
module radial_distortion_sample_coord_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  rdsc_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output rdsc_pkg::out_item_t                     out_data,
  input  logic                                    cfg_wr_en,
  input  logic [rdsc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [rdsc_pkg::ALPHA_BITS-1:0]         cfg_wdata
);
  import rdsc_pkg::*;

  typedef struct packed {
    coord_t              c;
    logic                neg;
    logic                ovf;
    logic [DIV_BITS-1:0] rem;
    logic [Q_BITS-1:0]   nq;
  } dstage_t;

  localparam logic signed [M_BITS-1:0]    M_POS = {2'b01, {Q_BITS{1'b0}}};
  localparam logic signed [M_BITS-1:0]    M_NEG = {2'b11, {Q_BITS{1'b0}}};
  localparam logic signed [IN_BITS+1:0]   ONE_S = 1;

  logic [IN_BITS-1:0]           patch_width_r;
  logic [IN_BITS-1:0]           patch_height_r;
  logic [IN_BITS-1:0]           resized_height_r;
  logic signed [ALPHA_BITS-1:0] alpha_r;

  logic [HALF_BITS-1:0]         hx;
  logic [HALF_BITS-1:0]         hy;
  logic [HALF_BITS-1:0]         rh;
  logic signed [IN_BITS+1:0]    wm1;
  logic signed [IN_BITS+1:0]    hm1;
  logic [DIV_BITS-1:0]          hx2_r;
  logic                         hx_zero_r;
  logic signed [LIM_BITS-1:0]   lim_x_r;
  logic signed [LIM_BITS-1:0]   lim_y_r;

  logic                         adv;

  logic                         s1_v_r;
  coord_t                       s1_c_r;
  logic                         s2_v_r;
  coord_t                       s2_c_r;
  logic [R2_BITS-1:0]           s2_r2_r;
  logic                         s3_v_r;
  coord_t                       s3_c_r;
  logic [PROD_BITS-1:0]         s3_p_r;
  logic                         s3_neg_r;

  logic signed [2*DELTA_BITS-1:0] sqx;
  logic signed [2*DELTA_BITS-1:0] sqy;
  logic [R2_BITS-1:0]           r2_nxt;
  logic [ALPHA_BITS-1:0]        alpha_mag;
  logic [PROD_BITS-1:0]         p_nxt;

  logic [Q_BITS:0]              dv_v_r;
  dstage_t                      dv_r   [Q_BITS+1];
  dstage_t                      dv_nxt [Q_BITS+1];

  logic                         s5_v_r;
  coord_t                       s5_c_r;
  logic signed [M_BITS-1:0]     s5_m_r;
  logic signed [M_BITS-1:0]     m_nxt;
  logic [M_BITS-1:0]            q_ext;

  logic                         s6_v_r;
  coord_t                       s6_c_r;
  logic signed [OFF_BITS-1:0]   s6_offx_r;
  logic signed [OFF_BITS-1:0]   s6_offy_r;
  logic signed [PROD2_BITS-1:0] px;
  logic signed [PROD2_BITS-1:0] py;

  logic signed [REF_BITS-1:0]   refx;
  logic signed [REF_BITS-1:0]   refy;
  logic signed [DELTA_BITS:0]   ysum;
  logic                         ok;
  out_item_t                    res;

  out_item_t                    out_r;
  logic                         out_valid_r;
  out_item_t                    skid_r;
  logic                         skid_valid_r;
  logic                         push;
  logic                         take;

  function automatic dstage_t div_step(dstage_t s, logic [DIV_BITS-1:0] d);
    logic [DIV_BITS:0] t;
    logic [DIV_BITS:0] diff;
    logic              ge;
    dstage_t           n;
    t    = {s.rem, s.nq[Q_BITS-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    n    = s;
    n.rem = ge ? diff[DIV_BITS-1:0] : t[DIV_BITS-1:0];
    n.nq  = {s.nq[Q_BITS-2:0], ge};
    return n;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_width_r    <= PATCH_WIDTH_RST;
      patch_height_r   <= PATCH_HEIGHT_RST;
      resized_height_r <= RESIZED_HEIGHT_RST;
      alpha_r          <= $signed(ALPHA_RST);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PATCH_WIDTH:    patch_width_r    <= cfg_wdata[IN_BITS-1:0];
        CFG_PATCH_HEIGHT:   patch_height_r   <= cfg_wdata[IN_BITS-1:0];
        CFG_RESIZED_HEIGHT: resized_height_r <= cfg_wdata[IN_BITS-1:0];
        CFG_ALPHA:          alpha_r          <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign hx  = patch_width_r[IN_BITS-1:1];
  assign hy  = patch_height_r[IN_BITS-1:1];
  assign rh  = resized_height_r[IN_BITS-1:1];
  assign wm1 = $signed({2'b00, patch_width_r}) - ONE_S;
  assign hm1 = $signed({2'b00, resized_height_r}) - ONE_S;

  // Values derived from the configuration, refreshed every cycle.
  always_ff @(posedge clk) begin
    hx2_r     <= hx * hx;
    hx_zero_r <= (hx == '0);
    lim_x_r   <= {wm1, {FRAC_BITS{1'b0}}};
    lim_y_r   <= {hm1, {FRAC_BITS{1'b0}}};
  end

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Stage 1: offsets from the patch center.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c_r.x  <= in_data.out_x;
      s1_c_r.dx <= $signed({1'b0, in_data.out_x}) - $signed({2'b00, hx});
      s1_c_r.dy <= $signed({1'b0, in_data.out_y}) - $signed({2'b00, hy});
    end
  end

  // Stage 2: squared radius.
  assign sqx    = $signed(s1_c_r.dx) * $signed(s1_c_r.dx);
  assign sqy    = $signed(s1_c_r.dy) * $signed(s1_c_r.dy);
  assign r2_nxt = sqx[R2_BITS-1:0] + sqy[R2_BITS-1:0];

  // Stage 3: magnitude of alpha times the squared radius.
  assign alpha_mag = alpha_r[ALPHA_BITS-1] ? (~alpha_r + 1'b1) : alpha_r;
  assign p_nxt     = alpha_mag * s2_r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c_r   <= s1_c_r;
      s2_r2_r  <= r2_nxt;
      s3_c_r   <= s2_c_r;
      s3_p_r   <= p_nxt;
      s3_neg_r <= alpha_r[ALPHA_BITS-1];
    end
  end

  // Stage 4 and the divider: one quotient bit per stage. A quotient that
  // would not fit in Q_BITS is flagged and saturated afterwards.
  always_comb begin
    dv_nxt[0].c   = s3_c_r;
    dv_nxt[0].neg = s3_neg_r;
    dv_nxt[0].ovf = ({{(DIV_BITS-TOP_BITS){1'b0}}, s3_p_r[PROD_BITS-1:LOW_BITS]} >= hx2_r);
    dv_nxt[0].rem = {{(DIV_BITS-TOP_BITS){1'b0}}, s3_p_r[PROD_BITS-1:LOW_BITS]};
    dv_nxt[0].nq  = {s3_p_r[LOW_BITS-1:0], {SCALE_SHIFT{1'b0}}};
    for (int i = 0; i < Q_BITS; i++) begin
      dv_nxt[i+1] = div_step(dv_r[i], hx2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else if (adv) begin
      dv_v_r <= {dv_v_r[Q_BITS-1:0], s3_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= Q_BITS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
    end
  end

  // Stage 5: signed, floored and saturated scale term.
  assign q_ext = {2'b00, dv_r[Q_BITS].nq};

  always_comb begin
    if (hx_zero_r) begin
      m_nxt = '0;
    end else if (dv_r[Q_BITS].ovf) begin
      m_nxt = dv_r[Q_BITS].neg ? M_NEG : M_POS;
    end else if (dv_r[Q_BITS].neg) begin
      m_nxt = (dv_r[Q_BITS].rem != '0) ? $signed(~q_ext) : $signed(-q_ext);
    end else begin
      m_nxt = $signed(q_ext);
    end
  end

  // Stage 6: displacement of each coordinate.
  assign px = $signed(s5_c_r.dx) * s5_m_r;
  assign py = $signed(s5_c_r.dy) * s5_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= dv_v_r[Q_BITS];
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_c_r    <= dv_r[Q_BITS].c;
      s5_m_r    <= m_nxt;
      s6_c_r    <= s5_c_r;
      s6_offx_r <= px[PROD2_BITS-1:OFF_SHIFT];
      s6_offy_r <= py[PROD2_BITS-1:OFF_SHIFT];
    end
  end

  // Final stage: reference point and range check.
  assign ysum = $signed({3'b000, rh}) + $signed({s6_c_r.dy[DELTA_BITS-1], s6_c_r.dy});
  assign refx = $signed({{(REF_BITS-IN_BITS-FRAC_BITS){1'b0}}, s6_c_r.x, {FRAC_BITS{1'b0}}})
              + $signed({s6_offx_r[OFF_BITS-1], s6_offx_r});
  assign refy = $signed({{(REF_BITS-DELTA_BITS-1-FRAC_BITS){ysum[DELTA_BITS]}}, ysum,
                         {FRAC_BITS{1'b0}}})
              + $signed({s6_offy_r[OFF_BITS-1], s6_offy_r});

  assign ok = !refx[REF_BITS-1] && !refy[REF_BITS-1]
           && (refx < $signed({{(REF_BITS-LIM_BITS){lim_x_r[LIM_BITS-1]}}, lim_x_r}))
           && (refy < $signed({{(REF_BITS-LIM_BITS){lim_y_r[LIM_BITS-1]}}, lim_y_r}));

  always_comb begin
    res = '0;
    if (ok) begin
      res.src_col      = refx[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
      res.src_row      = refy[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
      res.col_fraction = refx[FRAC_BITS-1:0];
      res.row_fraction = refy[FRAC_BITS-1:0];
      res.in_range     = 1'b1;
    end
  end

  // Output register with one skid entry.
  assign push = adv && s6_v_r;
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled without a stalled output");

  a_background_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.in_range) |->
      (out_r.src_col == '0 && out_r.src_row == '0 &&
       out_r.col_fraction == '0 && out_r.row_fraction == '0))
    else $error("background result carries nonzero coordinates");

  a_col_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.in_range) |->
      (({1'b0, out_r.src_col} + 1'b1) < {1'b0, patch_width_r}))
    else $error("in-range column lies outside the source width");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the radial distortion sampling point block
// Sends output pixel positions through the valid/stall input channel and
// checks each sampling point against a bit-exact fixed-point prediction.
// A directed table covers the field extremes, the center, the range edges
// and the degenerate sizes, and random phases follow with new register values.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdsc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     SETTLE_CYCLES  = 60;
  localparam int     PHASES         = 14;
  localparam int     PHASE_POINTS   = 124;
  localparam longint SCALE_CAP      = longint'(1) << 48;

  typedef struct packed {
    logic [IN_BITS-1:0]    width;
    logic [IN_BITS-1:0]    height;
    logic [IN_BITS-1:0]    rheight;
    logic [ALPHA_BITS-1:0] alpha;
  } warp_setup_t;

  typedef struct {
    bit        is_typed;
    out_item_t want;
  } point_plan_t;

  typedef struct {
    bit          is_setup;
    warp_setup_t setup;
    in_item_t    pos;
    bit          is_typed;
    out_item_t   want;
  } drill_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [ALPHA_BITS-1:0]     cfg_wdata = '0;

  logic [IN_BITS-1:0]        cur_width;
  logic [IN_BITS-1:0]        cur_height;
  logic [IN_BITS-1:0]        cur_rheight;
  logic signed [ALPHA_BITS-1:0] cur_alpha;

  point_plan_t point_plans[$];
  out_item_t   due_points[$];
  drill_row_t  drill[$];
  int          points_in = 0;
  int          points_out = 0;
  int          faults = 0;
  int          hold_left = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  radial_distortion_sample_coord_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic out_item_t locate_source(in_item_t p);
    longint    x, y, w, rht, hx, hy, rh, dx, dy, r2, m, one, refx, refy, q;
    out_item_t r;
    one  = longint'(1) << FRAC_BITS;
    x    = longint'(p.out_x);
    y    = longint'(p.out_y);
    w    = longint'(cur_width);
    rht  = longint'(cur_rheight);
    hx   = w / 2;
    hy   = longint'(cur_height) / 2;
    rh   = rht / 2;
    dx   = x - hx;
    dy   = y - hy;
    r2   = dx * dx + dy * dy;
    m    = 0;
    if (hx != 0) begin
      m = floor_quot(longint'(cur_alpha) * r2 * 65536, hx * hx);
      if (m > SCALE_CAP) m = SCALE_CAP;
      if (m < -SCALE_CAP) m = -SCALE_CAP;
    end
    refx = x * one + floor_quot(dx * m, longint'(1) << (30 - FRAC_BITS));
    refy = (rh + dy) * one + floor_quot(dy * m, longint'(1) << (30 - FRAC_BITS));
    r = '0;
    if (refx >= 0 && refx < (w - 1) * one && refy >= 0 && refy < (rht - 1) * one) begin
      q = refx / one;
      r.src_col = q[COORD_BITS-1:0];
      q = refy / one;
      r.src_row = q[COORD_BITS-1:0];
      q = refx % one;
      r.col_fraction = q[FRAC_BITS-1:0];
      q = refy % one;
      r.row_fraction = q[FRAC_BITS-1:0];
      r.in_range = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : track_samples
    point_plan_t plan;
    out_item_t   want;
    if (!rst_n) begin
      cur_width   = PATCH_WIDTH_RST;
      cur_height  = PATCH_HEIGHT_RST;
      cur_rheight = RESIZED_HEIGHT_RST;
      cur_alpha   = ALPHA_RST;
      hold_left   = 0;
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        plan = point_plans.pop_front();
        due_points.push_back(plan.is_typed ? plan.want : locate_source(in_data));
      end
      if (out_valid && !out_stall) begin
        points_out++;
        if (due_points.size() == 0) begin
          faults++;
          if (faults <= 10) $display("unexpected transfer: %p", out_data);
        end else begin
          want = due_points.pop_front();
          if (want.src_col !== out_data.src_col || want.src_row !== out_data.src_row ||
              want.col_fraction !== out_data.col_fraction ||
              want.row_fraction !== out_data.row_fraction ||
              want.in_range !== out_data.in_range) begin
            faults++;
            if (faults <= 10)
              $display("mismatch: expected col %0d row %0d fc %0d rf %0d in %0b,",
                       want.src_col, want.src_row, want.col_fraction,
                       want.row_fraction, want.in_range,
                       " got col %0d row %0d fc %0d rf %0d in %0b",
                       out_data.src_col, out_data.src_row, out_data.col_fraction,
                       out_data.row_fraction, out_data.in_range);
          end
        end
        hold_left = rx_calm ? 0 : $urandom_range(0, 8);
      end
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PATCH_WIDTH:    cur_width = cfg_wdata[IN_BITS-1:0];
          CFG_PATCH_HEIGHT:   cur_height = cfg_wdata[IN_BITS-1:0];
          CFG_RESIZED_HEIGHT: cur_rheight = cfg_wdata[IN_BITS-1:0];
          CFG_ALPHA:          cur_alpha = cfg_wdata;
          default: ;
        endcase
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("tb failed");
    $finish;
  end

  task automatic wait_drained();
    while (points_out < points_in) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ALPHA_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_setup(warp_setup_t s);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(CFG_PATCH_WIDTH, ALPHA_BITS'(s.width));
    write_reg(CFG_PATCH_HEIGHT, ALPHA_BITS'(s.height));
    write_reg(CFG_RESIZED_HEIGHT, ALPHA_BITS'(s.rheight));
    write_reg(CFG_ALPHA, s.alpha);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_point(in_item_t pos, bit is_typed, out_item_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_plans.push_back('{is_typed: is_typed, want: want});
    in_valid <= 1'b1;
    in_data  <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_in++;
  endtask

  function automatic warp_setup_t make_setup(int w, int h, int rh, int a);
    return {IN_BITS'(w), IN_BITS'(h), IN_BITS'(rh), ALPHA_BITS'(a)};
  endfunction

  function automatic void add_setup(int w, int h, int rh, int a);
    drill.push_back('{is_setup: 1'b1, setup: make_setup(w, h, rh, a), pos: '0,
                      is_typed: 1'b0, want: '0});
  endfunction

  function automatic void add_point(int x, int y);
    drill.push_back('{is_setup: 1'b0, setup: '0, pos: {IN_BITS'(x), IN_BITS'(y)},
                      is_typed: 1'b0, want: '0});
  endfunction

  function automatic void add_known(int x, int y, int col, int row, int cf, int rf, bit inr);
    drill.push_back('{is_setup: 1'b0, setup: '0, pos: {IN_BITS'(x), IN_BITS'(y)},
                      is_typed: 1'b1,
                      want: {COORD_BITS'(col), COORD_BITS'(row), FRAC_BITS'(cf),
                             FRAC_BITS'(rf), inr}});
  endfunction

  function automatic warp_setup_t draw_setup();
    warp_setup_t s;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      s.width   = IN_BITS'($urandom_range(2, 64));
      s.height  = IN_BITS'($urandom_range(2, 64));
      s.rheight = IN_BITS'($urandom_range(2, 64));
    end else begin
      s.width   = IN_BITS'($urandom_range(2, 2047));
      s.height  = IN_BITS'($urandom_range(2, 2047));
      s.rheight = IN_BITS'($urandom_range(2, 2047));
    end
    if (pick % 3 == 0) s.alpha = ALPHA_BITS'($urandom_range(0, 65535));
    else s.alpha = ALPHA_BITS'(int'($urandom_range(0, 6000)) - 3000);
    return s;
  endfunction

  initial begin : stimulus
    warp_setup_t setup;
    in_item_t    pos;

    add_known(480, 540, 480, 270, 0, 0, 1'b1);
    add_known(0, 0, 0, 0, 0, 0, 1'b0);
    add_known(2047, 2047, 0, 0, 0, 0, 1'b0);
    add_known(2047, 0, 0, 0, 0, 0, 1'b0);
    add_known(0, 2047, 0, 0, 0, 0, 1'b0);
    add_point(1023, 1024);
    add_point(481, 541);
    add_point(300, 400);
    add_setup(960, 1080, 540, -32768);
    add_known(480, 540, 480, 270, 0, 0, 1'b1);
    add_point(700, 800);
    add_point(100, 900);
    add_setup(960, 1080, 540, 32767);
    add_point(500, 560);
    add_point(470, 530);
    add_setup(960, 1080, 540, 0);
    add_known(959, 540, 0, 0, 0, 0, 1'b0);
    add_known(958, 808, 958, 538, 0, 0, 1'b1);
    add_known(0, 270, 0, 0, 0, 0, 1'b1);
    // A patch width below two leaves no half width and no valid column.
    add_setup(1, 1080, 540, 1638);
    add_known(0, 540, 0, 0, 0, 0, 1'b0);
    add_known(2047, 2047, 0, 0, 0, 0, 1'b0);
    add_setup(0, 0, 0, -32768);
    add_known(5, 5, 0, 0, 0, 0, 1'b0);
    add_setup(2047, 2047, 2047, -1);
    add_known(1023, 1023, 1023, 1023, 0, 0, 1'b1);
    add_point(0, 0);
    add_point(2046, 2046);
    add_setup(2, 2, 2, -1);
    add_known(1, 1, 0, 0, 0, 0, 1'b0);
    add_point(0, 0);
    add_point(0, 1);
    add_setup(2, 2, 0, 1638);
    add_known(0, 0, 0, 0, 0, 0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drill[i]) begin
      if (drill[i].is_setup) begin
        load_setup(drill[i].setup);
      end else begin
        send_point(drill[i].pos, drill[i].is_typed, drill[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setup = make_setup(2047, 2047, 2047, 32767);
        1:       setup = make_setup(2, 2, 2, -32768);
        2:       setup = make_setup(960, 1080, 540, 1638);
        default: setup = draw_setup();
      endcase
      load_setup(setup);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_POINTS; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          pos.out_x = IN_BITS'($urandom_range(0, 2047));
          pos.out_y = IN_BITS'($urandom_range(0, 2047));
        end else begin
          pos.out_x = IN_BITS'($urandom_range(0, int'(setup.width) - 1));
          pos.out_y = IN_BITS'($urandom_range(0, int'(setup.height) - 1));
        end
        if (ph == 3 && i == 60) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_point(pos, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0 && due_points.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
